>>> hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/dmc_pkg.sv
// types, codes and helpers for the direct-mapped cache hit counter
`timescale 1ns / 1ps

package dmc_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_STORE  = 2'd1,
        CMD_MODIFY = 2'd2,
        CMD_FETCH  = 2'd3
    } t_cmd;

    localparam logic CFG_SET_BITS    = 1'b0;
    localparam logic CFG_OFFSET_BITS = 1'b1;

    localparam int SET_BITS_W    = 4;
    localparam int OFFSET_BITS_W = 5;
    localparam int CFG_DATA_W    = 5;
    localparam int CFG_IDX_W     = 1;
    localparam int TAG_W         = 32;
    localparam int ADDR_W        = 32;
    localparam int CNT_W         = 32;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] address;
    } t_in;

    typedef struct packed {
        logic             was_hit;
        logic             was_miss;
        logic             was_evict;
        logic             extra_hit;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] evict_total;
    } t_out;

    typedef struct packed {
        t_cmd             kind;
        logic [TAG_W-1:0] tag;
    } t_op;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_LOOK  = 2'd2
    } t_back_state;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [1:0] n);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {{(CNT_W - 1){1'b0}}, n};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

endpackage

>>> hdl/dmc_front.sv
// front end: splits an access into command kind, set index and tag
`timescale 1ns / 1ps

module dmc_front import dmc_pkg::*; #(
    parameter int MAX_SET_BITS = 8,
    parameter int IDX_W        = 8
) (
    input  logic [SET_BITS_W-1:0]    i_set_bits,
    input  logic [OFFSET_BITS_W-1:0] i_offset_bits,
    input  t_in                      i_item,
    output t_op                      o_op,
    output logic [IDX_W-1:0]         o_set
);

    logic [4:0]       set_ext;
    logic [4:0]       set_lim;
    logic [5:0]       shift_sum;
    logic [IDX_W-1:0] addr_off;
    logic [IDX_W-1:0] set_mask;

    always_comb begin
        set_ext   = {1'b0, i_set_bits};
        set_lim   = (set_ext > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : set_ext;
        shift_sum = {1'b0, set_lim} + {1'b0, i_offset_bits};
        addr_off  = IDX_W'(i_item.address >> i_offset_bits);
        set_mask  = ~({IDX_W{1'b1}} << set_lim);

        o_op.kind = t_cmd'(i_item.cmd);
        o_op.tag  = (shift_sum >= 6'd32) ? '0 : (i_item.address >> shift_sum[4:0]);
        o_set     = addr_off & set_mask;
    end

endmodule

>>> hdl/dmc_queue.sv
// two-entry queue between front end and back end
`timescale 1ns / 1ps

module dmc_queue #(
    parameter int DATA_W = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty,
    output logic              o_full
);

    logic [DATA_W-1:0] r_slots [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              do_push;
    logic              do_pop;

    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hdl/dmc_back.sv
// back end: tag store lookup and fill, running totals, result register
`timescale 1ns / 1ps

module dmc_back import dmc_pkg::*; #(
    parameter int IDX_W     = 8,
    parameter int NUM_LINES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_op_valid,
    input  t_op              i_op,
    input  logic [IDX_W-1:0] i_set,
    output logic             o_pop,
    output t_back_stat       o_stat,
    output logic             o_res_valid,
    output t_out             o_res
);

    logic [TAG_W:0]   r_lines [NUM_LINES];
    logic [TAG_W:0]   r_rd_line;
    t_back_state      r_state;
    t_back_state      n_state;
    logic [IDX_W-1:0] r_clr_idx;
    logic [IDX_W-1:0] n_clr_idx;
    t_op              r_op;
    logic [IDX_W-1:0] r_set;
    logic [CNT_W-1:0] r_hit_cnt;
    logic [CNT_W-1:0] r_miss_cnt;
    logic [CNT_W-1:0] r_evict_cnt;
    logic [CNT_W-1:0] n_hit_cnt;
    logic [CNT_W-1:0] n_miss_cnt;
    logic [CNT_W-1:0] n_evict_cnt;
    logic             r_res_valid;
    logic             n_res_valid;
    t_out             r_res;
    t_out             n_res;
    logic             mem_re;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [TAG_W:0]   mem_wdata;
    logic             load_op;
    logic             hit;
    logic             is_modify;
    logic [1:0]       hit_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_idx   <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_hit_cnt   <= n_hit_cnt;
            r_miss_cnt  <= n_miss_cnt;
            r_evict_cnt <= n_evict_cnt;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (load_op) begin
            r_op  <= i_op;
            r_set <= i_set;
        end
    end

    // tag store: valid bit on top of the tag
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_line <= r_lines[i_set];
        end
        if (mem_we) begin
            r_lines[mem_waddr] <= mem_wdata;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_hit_cnt   = r_hit_cnt;
        n_miss_cnt  = r_miss_cnt;
        n_evict_cnt = r_evict_cnt;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_pop       = 1'b0;
        load_op     = 1'b0;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_set;
        mem_wdata   = {1'b1, r_op.tag};
        hit         = r_rd_line[TAG_W] && (r_rd_line[TAG_W-1:0] == r_op.tag);
        is_modify   = (r_op.kind == CMD_MODIFY);
        hit_inc     = {1'b0, hit} + {1'b0, is_modify};

        case (r_state)
            BK_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = '0;
                n_clr_idx = r_clr_idx + IDX_W'(1);
                if (r_clr_idx == IDX_W'(NUM_LINES - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_op_valid) begin
                    o_pop = 1'b1;
                    if (i_op.kind == CMD_FETCH) begin
                        n_res_valid       = 1'b1;
                        n_res.was_hit     = 1'b0;
                        n_res.was_miss    = 1'b0;
                        n_res.was_evict   = 1'b0;
                        n_res.extra_hit   = 1'b0;
                        n_res.hit_total   = r_hit_cnt;
                        n_res.miss_total  = r_miss_cnt;
                        n_res.evict_total = r_evict_cnt;
                    end else begin
                        load_op = 1'b1;
                        mem_re  = 1'b1;
                        n_state = BK_LOOK;
                    end
                end
            end
            BK_LOOK: begin
                mem_we    = !hit;
                n_hit_cnt = sat_add(r_hit_cnt, hit_inc);
                if (!hit) begin
                    n_miss_cnt = sat_add(r_miss_cnt, 2'd1);
                    if (r_rd_line[TAG_W]) begin
                        n_evict_cnt = sat_add(r_evict_cnt, 2'd1);
                    end
                end
                n_res_valid       = 1'b1;
                n_res.was_hit     = hit;
                n_res.was_miss    = !hit;
                n_res.was_evict   = !hit && r_rd_line[TAG_W];
                n_res.extra_hit   = is_modify;
                n_res.hit_total   = n_hit_cnt;
                n_res.miss_total  = n_miss_cnt;
                n_res.evict_total = n_evict_cnt;
                n_state           = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_stat.clearing = (r_state == BK_CLEAR);
    assign o_res_valid     = r_res_valid;
    assign o_res           = r_res;

endmodule

>>> hdl/direct_mapped_cache_hit_counter.sv
// an access passes a queue slot, the tag store read, BK_LOOK and the result register
// a fetch skips the read and BK_LOOK; one fetch per cycle while no access is in BK_LOOK
// a two-entry queue lets start be taken while the back end works; busy when it is full
// reset: synchronous; a clearing pass over all 2**MAX_SET_BITS lines follows, busy meanwhile
// results are strobed for one cycle on o_valid and cannot be stalled
`timescale 1ns / 1ps
`include "assert_macros.svh"

module direct_mapped_cache_hit_counter import dmc_pkg::*; #(
    parameter int MAX_SET_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  t_in                   i_item,
    output logic                  o_valid,
    output t_out                  o_result
);

    localparam int IDX_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_LINES = 1 << MAX_SET_BITS;
    localparam int Q_DATA_W  = IDX_W + $bits(t_op);

    logic [SET_BITS_W-1:0]    r_set_bits;
    logic [OFFSET_BITS_W-1:0] r_offset_bits;
    t_op                      front_op;
    logic [IDX_W-1:0]         front_set;
    logic [Q_DATA_W-1:0]      q_out;
    logic                     q_empty;
    logic                     q_full;
    logic                     q_pop;
    logic                     accept;
    t_back_stat               back_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= '0;
            r_offset_bits <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SET_BITS: begin
                    r_set_bits <= i_cfg_data[SET_BITS_W-1:0];
                end
                CFG_OFFSET_BITS: begin
                    r_offset_bits <= i_cfg_data[OFFSET_BITS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign busy   = q_full || back_stat.clearing;
    assign accept = start && !busy;

    dmc_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .IDX_W        (IDX_W)
    ) u_front (
        .i_set_bits    (r_set_bits),
        .i_offset_bits (r_offset_bits),
        .i_item        (i_item),
        .o_op          (front_op),
        .o_set         (front_set)
    );

    dmc_queue #(
        .DATA_W (Q_DATA_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  ({front_set, front_op}),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    dmc_back #(
        .IDX_W     (IDX_W),
        .NUM_LINES (NUM_LINES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (!q_empty),
        .i_op        (t_op'(q_out[$bits(t_op)-1:0])),
        .i_set       (q_out[Q_DATA_W-1:$bits(t_op)]),
        .o_pop       (q_pop),
        .o_stat      (back_stat),
        .o_res_valid (o_valid),
        .o_res       (o_result)
    );

    `ASSERT_SAME(a_hit_xor_miss, i_clk, i_rst_n, o_valid && o_result.was_hit, !o_result.was_miss)
    `ASSERT_SAME(a_evict_needs_miss, i_clk, i_rst_n, o_valid && o_result.was_evict, o_result.was_miss)
    `ASSERT_SAME(a_clear_blocks, i_clk, i_rst_n, back_stat.clearing, busy && !o_valid)
    `ASSERT_NEXT(a_pop_from_idle, i_clk, i_rst_n, q_pop, !back_stat.clearing)

endmodule

>>> tb/tb.sv
// self-checking testbench for the direct-mapped cache hit counter
`timescale 1ns / 1ps

module tb;
    import dmc_pkg::*;

    localparam int LINE_BITS = 8;
    localparam int NUM_LINES = 1 << LINE_BITS;
    localparam int WATCHDOG = 2000;
    localparam int MAX_GAP = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int NUM_PHASES = 8;

    class cache_scoreboard;
        bit line_valid[NUM_LINES];
        bit [TAG_W-1:0] line_tag[NUM_LINES];
        bit [CNT_W-1:0] hits;
        bit [CNT_W-1:0] misses;
        bit [CNT_W-1:0] evicts;
        bit [SET_BITS_W-1:0] set_bits;
        bit [OFFSET_BITS_W-1:0] offset_bits;
        t_out expected_q[$];
        int errors;

        function bit [CNT_W-1:0] sat_inc(bit [CNT_W-1:0] a);
            return (a == '1) ? a : a + 1;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] value);
            if (idx == CFG_SET_BITS) begin
                set_bits = value[SET_BITS_W-1:0];
            end else begin
                offset_bits = value[OFFSET_BITS_W-1:0];
            end
        endfunction

        function void note_access(t_in beat);
            t_out res;
            int s;
            int sh;
            bit [TAG_W-1:0] tag;
            bit [31:0] mask;
            int set_idx;
            res = '0;
            if (beat.cmd != CMD_FETCH) begin
                s = (set_bits > LINE_BITS) ? LINE_BITS : set_bits;
                sh = s + offset_bits;
                tag = (sh >= 32) ? '0 : beat.address >> sh;
                mask = (32'd1 << s) - 1;
                set_idx = int'((beat.address >> offset_bits) & mask);
                if (line_valid[set_idx] && line_tag[set_idx] == tag) begin
                    res.was_hit = 1'b1;
                    hits = sat_inc(hits);
                end else begin
                    res.was_miss = 1'b1;
                    misses = sat_inc(misses);
                    if (line_valid[set_idx]) begin
                        res.was_evict = 1'b1;
                        evicts = sat_inc(evicts);
                    end
                    line_valid[set_idx] = 1'b1;
                    line_tag[set_idx] = tag;
                end
                if (beat.cmd == CMD_MODIFY) begin
                    res.extra_hit = 1'b1;
                    hits = sat_inc(hits);
                end
            end
            res.hit_total = hits;
            res.miss_total = misses;
            res.evict_total = evicts;
            expected_q.push_back(res);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                $error("result beat with no access pending");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.was_hit !== want.was_hit) begin
                $error("was_hit: expected %0d actual %0d", want.was_hit, got.was_hit);
                errors++;
            end
            if (got.was_miss !== want.was_miss) begin
                $error("was_miss: expected %0d actual %0d", want.was_miss, got.was_miss);
                errors++;
            end
            if (got.was_evict !== want.was_evict) begin
                $error("was_evict: expected %0d actual %0d", want.was_evict, got.was_evict);
                errors++;
            end
            if (got.extra_hit !== want.extra_hit) begin
                $error("extra_hit: expected %0d actual %0d", want.extra_hit, got.extra_hit);
                errors++;
            end
            if (got.hit_total !== want.hit_total) begin
                $error("hit_total: expected %0d actual %0d", want.hit_total, got.hit_total);
                errors++;
            end
            if (got.miss_total !== want.miss_total) begin
                $error("miss_total: expected %0d actual %0d", want.miss_total,
                       got.miss_total);
                errors++;
            end
            if (got.evict_total !== want.evict_total) begin
                $error("evict_total: expected %0d actual %0d", want.evict_total,
                       got.evict_total);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic start;
    logic busy;
    t_in i_item;
    logic o_valid;
    t_out o_result;

    cache_scoreboard sb;
    int idle_cycles;
    logic [ADDR_W-1:0] addr_pool[12];
    int geo_set;
    int geo_off;

    direct_mapped_cache_hit_counter u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_valid) begin
                sb.check_result(o_result);
            end
            if (start && !busy) begin
                sb.note_access(i_item);
            end
            if (o_valid || (start && !busy)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG) begin
                $display("direct_mapped_cache_hit_counter regression: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic set_geometry(bit [SET_BITS_W-1:0] sbits, bit [OFFSET_BITS_W-1:0] obits);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_SET_BITS;
        i_cfg_data <= CFG_DATA_W'(sbits);
        @(posedge i_clk);
        sb.write_reg(CFG_SET_BITS, CFG_DATA_W'(sbits));
        i_cfg_idx <= CFG_OFFSET_BITS;
        i_cfg_data <= CFG_DATA_W'(obits);
        @(posedge i_clk);
        sb.write_reg(CFG_OFFSET_BITS, CFG_DATA_W'(obits));
        i_cfg_we <= 1'b0;
        geo_set = (sbits > LINE_BITS) ? LINE_BITS : sbits;
        geo_off = obits;
    endtask

    task automatic send_access(t_cmd kind, logic [ADDR_W-1:0] addr, int idle_pct);
        int gap;
        gap = 0;
        while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item.cmd <= kind;
        i_item.address <= addr;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] r;
        logic [ADDR_W-1:0] low_mask;
        int roll;
        base = addr_pool[$urandom_range(0, 11)];
        r = $urandom;
        low_mask = (32'd1 << geo_off) - 1;
        roll = $urandom_range(0, 99);
        // same line, same set with another tag, or anywhere
        if (roll < 55) begin
            return base ^ (r & low_mask);
        end
        if (roll < 75) begin
            if (geo_set + geo_off >= 32) begin
                return base ^ (r & low_mask);
            end
            return base ^ (r << (geo_set + geo_off));
        end
        return r;
    endfunction

    initial begin
        int set_list[NUM_PHASES];
        int off_list[NUM_PHASES];
        int idle_list[4];
        int idle_pct;
        sb = new();
        set_list = '{0, 8, 15, 4, 1, 12, 8, 3};
        off_list = '{0, 0, 31, 6, 24, 20, 3, 10};
        idle_list = '{0, 52, 0, 27};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        start = 1'b0;
        i_item = '0;
        geo_set = 0;
        geo_off = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fill, hit, modify, eviction, fetch
        set_geometry(4'd2, 5'd4);
        send_access(CMD_LOAD, 32'h0000_0000, 0);
        send_access(CMD_LOAD, 32'h0000_0000, 0);
        send_access(CMD_STORE, 32'h0000_000F, 0);
        send_access(CMD_MODIFY, 32'h0000_0000, 0);
        send_access(CMD_MODIFY, 32'h0000_0040, 0);
        send_access(CMD_FETCH, 32'hFFFF_FFFF, 0);
        send_access(CMD_LOAD, 32'hFFFF_FFFF, 0);
        send_access(CMD_STORE, 32'hFFFF_FFFF, 0);
        send_access(CMD_MODIFY, 32'h1234_5678, 0);
        send_access(CMD_FETCH, 32'h0000_0000, 0);
        drain();
        // oversized set bits and a tag shift past the word
        set_geometry(4'd15, 5'd31);
        send_access(CMD_LOAD, 32'h8000_0000, 0);
        send_access(CMD_LOAD, 32'h7FFF_FFFF, 0);
        send_access(CMD_MODIFY, 32'hFFFF_FFFF, 0);
        send_access(CMD_FETCH, 32'h8000_0000, 0);
        drain();
        // single set, tag is the whole address
        set_geometry(4'd0, 5'd0);
        send_access(CMD_LOAD, 32'hFFFF_FFFF, 0);
        send_access(CMD_LOAD, 32'hFFFF_FFFF, 0);
        send_access(CMD_STORE, 32'h0000_0000, 0);
        drain();
        set_geometry(4'd8, 5'd24);
        send_access(CMD_LOAD, 32'hAB00_0000, 0);
        send_access(CMD_STORE, 32'hABFF_FFFF, 0);
        send_access(CMD_MODIFY, 32'h5500_0000, 0);
        send_access(CMD_LOAD, 32'h0000_0000, 0);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_geometry(SET_BITS_W'(set_list[p]), OFFSET_BITS_W'(off_list[p]));
            foreach (addr_pool[k]) begin
                addr_pool[k] = $urandom;
            end
            idle_pct = idle_list[p % 4];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_access(t_cmd'($urandom_range(0, 3)), pick_address(), idle_pct);
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("direct_mapped_cache_hit_counter regression: pass");
        end else begin
            $display("direct_mapped_cache_hit_counter regression: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/dmc_pkg.sv
hdl/dmc_front.sv
hdl/dmc_queue.sv
hdl/dmc_back.sv
hdl/direct_mapped_cache_hit_counter.sv
tb/tb.sv
